// ===== rtl/v3a_pkg.sv =====
`timescale 1ns / 1ps

package v3a_pkg;

  localparam int FIELD_BITS = 32;

  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_SUB       = 3'd1;
  localparam logic [2:0] CMD_SCALE     = 3'd2;
  localparam logic [2:0] CMD_DIVIDE    = 3'd3;
  localparam logic [2:0] CMD_CROSS     = 3'd4;
  localparam logic [2:0] CMD_DOT       = 3'd5;
  localparam logic [2:0] CMD_NORM      = 3'd6;
  localparam logic [2:0] CMD_NORMALIZE = 3'd7;

endpackage

// ===== rtl/vector3_alu.sv =====
`timescale 1ns / 1ps

// Three-component vector unit in signed fixed point with FRAC_BITS fraction bits on
// operands of min(WORD_BITS, 32) bits. It accepts one item per cycle while the output
// is not stalled. Each item passes through the lane stages, the square-root pipeline,
// one root bit per stage, and then the per-lane dividers, one quotient bit per stage.
// The whole pipeline advances together, so it holds while a finished result is not
// taken.
module vector3_alu
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar
  input  logic [2:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // r_x, r_y, r_z
  output logic [1:0]   m_tuser    // saturated, div_by_zero
);

  localparam int EW    = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int Q     = EW + F;
  localparam int T_N   = EW + 5;
  localparam int T_Q   = T_N + Q;
  localparam int T_OUT = T_Q + 1;
  localparam int CW    = (2 * EW + 3 > Q + 1) ? 2 * EW + 3 : Q + 1;
  localparam logic signed [CW-1:0] HI = {{(CW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [CW-1:0] LO = ~HI;
  localparam logic signed [CW-1:0] HALF = CW'(1) << (F - 1);

  typedef struct packed {
    logic [2:0]           cmd;
    logic signed [EW-1:0] ax;
    logic signed [EW-1:0] ay;
    logic signed [EW-1:0] az;
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] lr0;
    logic signed [EW-1:0] lr1;
    logic signed [EW-1:0] lr2;
    logic [2:0]           lsat;
    logic signed [EW-1:0] dot;
    logic                 dsat;
    logic [EW:0]          n;
  } pipe_t;

  function automatic logic [EW:0] clipc(input logic signed [CW-1:0] v);
    logic [EW:0] o;
    if (v > HI) begin
      o = {1'b1, HI[EW-1:0]};
    end else if (v < LO) begin
      o = {1'b1, LO[EW-1:0]};
    end else begin
      o = {1'b0, v[EW-1:0]};
    end
    return o;
  endfunction

  logic                   en;
  logic [T_OUT:1]         vld;
  pipe_t                  pipe [1:T_Q];
  pipe_t                  pin  [1:T_Q];
  logic signed [EW-1:0]   bx, by, bz;
  logic signed [2*EW-1:0] tx, ty, tz;
  logic signed [EW-1:0]   rx4, ry4, rz4;
  logic                   sx4, sy4, sz4;
  logic signed [2*EW+1:0] msum;
  logic [EW:0]            nroot;
  logic signed [CW-1:0]   dsum;
  logic [EW:0]            dcl;
  logic [EW:0]            den;
  logic [EW:0]            mg0, mg1, mg2;
  logic                   sneg;
  logic [Q-1:0]           q0, q1, q2;
  logic                   qn0, qn1, qn2;
  logic [EW:0]            c0, c1, c2;
  logic signed [EW-1:0]   rx, ry, rz;
  logic                   sat, dz;

  assign en       = !vld[T_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx <= $signed(s_tdata[96+EW-1:96]);
      by <= $signed(s_tdata[128+EW-1:128]);
      bz <= $signed(s_tdata[160+EW-1:160]);
    end
  end

  always_comb begin
    dsum = (CW'(msum) + HALF) >>> F;
    dcl  = clipc(dsum);
    pin[1]     = '0;
    pin[1].cmd = s_tuser;
    pin[1].ax  = $signed(s_tdata[EW-1:0]);
    pin[1].ay  = $signed(s_tdata[32+EW-1:32]);
    pin[1].az  = $signed(s_tdata[64+EW-1:64]);
    pin[1].s   = $signed(s_tdata[192+EW-1:192]);
    for (int k = 2; k <= T_Q; k++) begin
      pin[k] = pipe[k-1];
      if (k == 5) begin
        pin[k].lr0  = rx4;
        pin[k].lr1  = ry4;
        pin[k].lr2  = rz4;
        pin[k].lsat = {sz4, sy4, sx4};
        pin[k].dot  = dcl[EW-1:0];
        pin[k].dsat = dcl[EW];
      end
      if (k == T_N + 1) begin
        pin[k].n = nroot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= T_Q; k++) begin
        pipe[k] <= pin[k];
      end
    end
  end

  v3a_lane #(.W(EW), .F(F)) u_lane_x (
    .clk(clk), .en(en), .cmd(pipe[1].cmd), .a(pipe[1].ax), .b(bx),
    .c1a(pipe[1].ay), .c1b(bz), .c2a(pipe[1].az), .c2b(by), .s(pipe[1].s),
    .term(tx), .res(rx4), .sat(sx4)
  );

  v3a_lane #(.W(EW), .F(F)) u_lane_y (
    .clk(clk), .en(en), .cmd(pipe[1].cmd), .a(pipe[1].ay), .b(by),
    .c1a(pipe[1].az), .c1b(bx), .c2a(pipe[1].ax), .c2b(bz), .s(pipe[1].s),
    .term(ty), .res(ry4), .sat(sy4)
  );

  v3a_lane #(.W(EW), .F(F)) u_lane_z (
    .clk(clk), .en(en), .cmd(pipe[1].cmd), .a(pipe[1].az), .b(bz),
    .c1a(pipe[1].ax), .c1b(by), .c2a(pipe[1].ay), .c2b(bx), .s(pipe[1].s),
    .term(tz), .res(rz4), .sat(sz4)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      msum <= (2*EW+2)'(tx) + (2*EW+2)'(ty) + (2*EW+2)'(tz);
    end
  end

  v3a_sqrt #(.W(EW)) u_sqrt (
    .clk(clk), .en(en), .s(msum[2*EW-1:0]), .n(nroot)
  );

  always_comb begin
    mg0  = pipe[T_N].ax[EW-1] ? -(EW+1)'(pipe[T_N].ax) : (EW+1)'(pipe[T_N].ax);
    mg1  = pipe[T_N].ay[EW-1] ? -(EW+1)'(pipe[T_N].ay) : (EW+1)'(pipe[T_N].ay);
    mg2  = pipe[T_N].az[EW-1] ? -(EW+1)'(pipe[T_N].az) : (EW+1)'(pipe[T_N].az);
    sneg = (pipe[T_N].cmd == CMD_DIVIDE) && pipe[T_N].s[EW-1];
    if (pipe[T_N].cmd == CMD_NORMALIZE) begin
      den = nroot;
    end else begin
      den = pipe[T_N].s[EW-1] ? -(EW+1)'(pipe[T_N].s) : (EW+1)'(pipe[T_N].s);
    end
  end

  v3a_div #(.W(EW), .F(F)) u_div_x (
    .clk(clk), .en(en), .num(mg0[EW-1:0]), .den(den),
    .neg(pipe[T_N].ax[EW-1] ^ sneg), .q(q0), .q_neg(qn0)
  );

  v3a_div #(.W(EW), .F(F)) u_div_y (
    .clk(clk), .en(en), .num(mg1[EW-1:0]), .den(den),
    .neg(pipe[T_N].ay[EW-1] ^ sneg), .q(q1), .q_neg(qn1)
  );

  v3a_div #(.W(EW), .F(F)) u_div_z (
    .clk(clk), .en(en), .num(mg2[EW-1:0]), .den(den),
    .neg(pipe[T_N].az[EW-1] ^ sneg), .q(q2), .q_neg(qn2)
  );

  always_comb begin
    c0  = clipc(qn0 ? -CW'(q0) : CW'(q0));
    c1  = clipc(qn1 ? -CW'(q1) : CW'(q1));
    c2  = clipc(qn2 ? -CW'(q2) : CW'(q2));
    rx  = '0;
    ry  = '0;
    rz  = '0;
    sat = 1'b0;
    dz  = 1'b0;
    case (pipe[T_Q].cmd)
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_CROSS: begin
        rx  = pipe[T_Q].lr0;
        ry  = pipe[T_Q].lr1;
        rz  = pipe[T_Q].lr2;
        sat = |pipe[T_Q].lsat;
      end
      CMD_DOT: begin
        rx  = pipe[T_Q].dot;
        sat = pipe[T_Q].dsat;
      end
      CMD_NORM: begin
        {sat, rx} = clipc($signed(CW'(pipe[T_Q].n)));
      end
      CMD_DIVIDE, CMD_NORMALIZE: begin
        if ((pipe[T_Q].cmd == CMD_DIVIDE && pipe[T_Q].s == '0) ||
            (pipe[T_Q].cmd == CMD_NORMALIZE && pipe[T_Q].n == '0)) begin
          dz = 1'b1;
        end else begin
          rx  = c0[EW-1:0];
          ry  = c1[EW-1:0];
          rz  = c2[EW-1:0];
          sat = c0[EW] | c1[EW] | c2[EW];
        end
      end
      default: begin
        dz = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {32'(rz), 32'(ry), 32'(rx)};
      m_tuser <= {dz, sat};
    end
  end

`ifndef NO_ASSERTIONS
  a_stall: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the output stall");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("saturated and divide-by-zero raised together");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
    else $error("divide-by-zero item carries nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled item changed");
`endif

endmodule

// ===== rtl/v3a_lane.sv =====
`timescale 1ns / 1ps

module v3a_lane
  import v3a_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0]            cmd,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  input  logic signed [W-1:0]   c1a,
  input  logic signed [W-1:0]   c1b,
  input  logic signed [W-1:0]   c2a,
  input  logic signed [W-1:0]   c2b,
  input  logic signed [W-1:0]   s,
  output logic signed [2*W-1:0] term,
  output logic signed [W-1:0]   res,
  output logic                  sat
);

  localparam int X = 2 * W + 3;
  localparam logic signed [X-1:0] HI = {{(X-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [X-1:0] LO = ~HI;
  localparam logic signed [X-1:0] HALF = X'(1) << (F - 1);

  function automatic logic [W:0] clipw(input logic signed [X-1:0] v);
    logic [W:0] o;
    if (v > HI) begin
      o = {1'b1, HI[W-1:0]};
    end else if (v < LO) begin
      o = {1'b1, LO[W-1:0]};
    end else begin
      o = {1'b0, v[W-1:0]};
    end
    return o;
  endfunction

  logic signed [W-1:0]   ma, mb;
  logic [2:0]            cmd1, cmd2;
  logic signed [2*W-1:0] p0, p1;
  logic signed [W:0]     as1, as2;
  logic signed [2*W:0]   v;
  logic signed [X-1:0]   vx, rnd;
  logic [W:0]            cl;

  always_comb begin
    ma = a;
    mb = b;
    case (cmd)
      CMD_SCALE: begin
        mb = s;
      end
      CMD_CROSS: begin
        ma = c1a;
        mb = c1b;
      end
      CMD_NORM, CMD_NORMALIZE: begin
        mb = a;
      end
      default: begin
        mb = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= ma * mb;
      p1   <= c2a * c2b;
      as1  <= (cmd == CMD_SUB) ? a - b : a + b;
      cmd1 <= cmd;
      v    <= (cmd1 == CMD_CROSS) ? p0 - p1 : p0;
      term <= p0;
      as2  <= as1;
      cmd2 <= cmd1;
    end
  end

  always_comb begin
    vx  = X'(v);
    rnd = (vx + HALF) >>> F;
    case (cmd2)
      CMD_ADD, CMD_SUB: cl = clipw(X'(as2));
      CMD_SCALE, CMD_CROSS: cl = clipw(rnd);
      default: cl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= cl[W-1:0];
      sat <= cl[W];
    end
  end

endmodule

// ===== rtl/v3a_sqrt.sv =====
`timescale 1ns / 1ps

module v3a_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] s,
  output logic [W:0]     n
);

  logic [2*W-1:0] xs [W+1];
  logic [2*W-1:0] rs [W+1];

  assign xs[0] = s;
  assign rs[0] = '0;

  for (genvar j = 0; j < W; j++) begin : g_step
    localparam logic [2*W-1:0] BIT = (2*W)'(1) << (2 * W - 2 - 2 * j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (xs[j] >= rs[j] + BIT) begin
          xs[j+1] <= xs[j] - (rs[j] + BIT);
          rs[j+1] <= (rs[j] >> 1) + BIT;
        end else begin
          xs[j+1] <= xs[j];
          rs[j+1] <= rs[j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n <= rs[W][W:0] + (W+1)'(xs[W] > rs[W]);
    end
  end

endmodule

// ===== rtl/v3a_div.sv =====
`timescale 1ns / 1ps

module v3a_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     num,
  input  logic [W:0]       den,
  input  logic             neg,
  output logic [W+F-1:0]   q,
  output logic             q_neg
);

  localparam int Q = W + F;

  logic [W:0]   rem [Q+1];
  logic [Q-1:0] nb  [Q+1];
  logic [Q-1:0] qq  [Q+1];
  logic [W:0]   dd  [Q+1];
  logic         ng  [Q+1];

  assign rem[0] = '0;
  assign nb[0]  = Q'(num) << F;
  assign qq[0]  = '0;
  assign dd[0]  = den;
  assign ng[0]  = neg;

  for (genvar j = 0; j < Q; j++) begin : g_step
    logic [W+1:0] t;
    assign t = {rem[j], nb[j][Q-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, dd[j]}) begin
          rem[j+1] <= (W+1)'(t - {1'b0, dd[j]});
          qq[j+1]  <= {qq[j][Q-2:0], 1'b1};
        end else begin
          rem[j+1] <= t[W:0];
          qq[j+1]  <= {qq[j][Q-2:0], 1'b0};
        end
        nb[j+1] <= nb[j] << 1;
        dd[j+1] <= dd[j];
        ng[j+1] <= ng[j];
      end
    end
  end

  assign q     = qq[Q];
  assign q_neg = ng[Q];

endmodule
